// ----- design/blifo_pkg.sv -----
// Shared constants, operation and status codes, and result type of the bounded LIFO stack.
`timescale 1ns / 1ps

package blifo_pkg;

  // Storage geometry.
  localparam int DEPTH        = 256;
  localparam int DATA_WIDTH   = 32;
  localparam int MIN_CAPACITY = 5;

  // Fixed field widths of the ports.
  localparam int OP_W       = 3;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int CAPACITY_W = 9;

  // Derived widths: the count must hold DEPTH itself, the address indexes DEPTH entries.
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CMP_W  = (CNT_W > CAPACITY_W) ? CNT_W : CAPACITY_W;

  localparam logic [CAPACITY_W-1:0] CAPACITY_RESET = CAPACITY_W'(256);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_TOP     = 3'd2,
    OP_TOP_POP = 3'd3,
    OP_CLEAR   = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] top_value;
    logic                      value_valid;
    status_t                   status;
    logic                      is_empty;
    logic                      is_full;
  } result_t;

  // Stored word to port value: sign-extend from the storage width, then cut to the port width.
  function automatic logic signed [VALUE_W-1:0] widen(input logic [DATA_WIDTH-1:0] word);
    logic signed [DATA_WIDTH-1:0] sword;
    sword = signed'(word);
    return VALUE_W'(sword);
  endfunction

endpackage

// ----- design/blifo_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module blifo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- design/bounded_lifo_stack.sv -----
// Bounded LIFO stack: top register, RAM-backed storage and a two-word result buffer.
// Results are registered in the head, or the spare while it stalls. Throughput: one
// operation per cycle while the spare is empty; the RAM read port fetches the word
// beneath the top every cycle, so a pop refills the top register without a stall.
// Reset clears the entry count, sets the capacity to 256 and empties the result buffer.
// The storage RAM is not cleared; only entries written by a push are ever used.
`timescale 1ns / 1ps

module bounded_lifo_stack (
  input  logic                                    clk,
  input  logic                                    rst,
  // Configuration write channel.
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [blifo_pkg::CAPACITY_W-1:0]        cfg_data,
  // Operation channel.
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [blifo_pkg::OP_W-1:0]              op,
  input  logic signed [blifo_pkg::VALUE_W-1:0]    push_value,
  // Result channel.
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [blifo_pkg::VALUE_W-1:0]    top_value,
  output logic                                    value_valid,
  output logic [blifo_pkg::STATUS_W-1:0]          status,
  output logic                                    is_empty,
  output logic                                    is_full
);

  // Control and stack state.
  logic [blifo_pkg::CAPACITY_W-1:0] capacity;
  logic [blifo_pkg::CNT_W-1:0]      count;
  logic [blifo_pkg::CNT_W-1:0]      count_next;
  logic [blifo_pkg::DATA_WIDTH-1:0] top_word;
  logic [blifo_pkg::DATA_WIDTH-1:0] top_word_next;

  // RAM interface.
  logic                              wr_en;
  logic [blifo_pkg::ADDR_W-1:0]      rd_addr;
  logic [blifo_pkg::DATA_WIDTH-1:0]  rd_data;
  logic [blifo_pkg::DATA_WIDTH-1:0]  push_word;

  // Limits and the result being formed.
  logic [blifo_pkg::CMP_W-1:0] cap_ext;
  logic [blifo_pkg::CMP_W-1:0] eff_cap;
  logic                        full_now;
  logic                        empty_now;
  logic                        in_fire;
  logic                        out_fire;
  blifo_pkg::result_t          res;

  // Result buffer: a head register and a spare that catches a word while the head stalls.
  blifo_pkg::result_t out_word;
  blifo_pkg::result_t spare_word;
  logic               spare_valid;

  assign cfg_ready = 1'b1;
  assign in_ready  = !spare_valid;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign push_word = blifo_pkg::DATA_WIDTH'($unsigned(push_value));

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= blifo_pkg::CAPACITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  // Effective capacity is the register clamped to the supported range.
  always_comb begin
    cap_ext = blifo_pkg::CMP_W'(capacity);
    if (cap_ext < blifo_pkg::CMP_W'(blifo_pkg::MIN_CAPACITY)) begin
      eff_cap = blifo_pkg::CMP_W'(blifo_pkg::MIN_CAPACITY);
    end else if (cap_ext > blifo_pkg::CMP_W'(blifo_pkg::DEPTH)) begin
      eff_cap = blifo_pkg::CMP_W'(blifo_pkg::DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
    full_now  = blifo_pkg::CMP_W'(count) >= eff_cap;
    empty_now = (count == '0);
  end

  // Operation decode: next count, next top word, RAM write and the result word.
  always_comb begin
    count_next      = count;
    top_word_next   = top_word;
    wr_en           = 1'b0;
    res.top_value   = '0;
    res.value_valid = 1'b0;
    res.status      = blifo_pkg::ST_OK;
    if (in_fire) begin
      case (op)
        blifo_pkg::OP_PUSH: begin
          if (full_now) begin
            res.status = blifo_pkg::ST_OVERFLOW;
          end else begin
            wr_en         = 1'b1;
            count_next    = count + 1'b1;
            top_word_next = push_word;
          end
        end
        blifo_pkg::OP_POP, blifo_pkg::OP_TOP, blifo_pkg::OP_TOP_POP: begin
          if (empty_now) begin
            res.status = blifo_pkg::ST_UNDERFLOW;
          end else begin
            if (op != blifo_pkg::OP_POP) begin
              res.top_value   = blifo_pkg::widen(top_word);
              res.value_valid = 1'b1;
            end
            if (op != blifo_pkg::OP_TOP) begin
              // The word beneath the top was fetched from the RAM last cycle.
              count_next    = count - 1'b1;
              top_word_next = rd_data;
            end
          end
        end
        blifo_pkg::OP_CLEAR: begin
          count_next = '0;
        end
        default: begin
        end
      endcase
    end
    res.is_empty = (count_next == '0);
    res.is_full  = blifo_pkg::CMP_W'(count_next) >= eff_cap;
  end

  // Prefetch the word beneath the new top; below two entries the data goes unused.
  assign rd_addr = blifo_pkg::ADDR_W'(count_next - blifo_pkg::CNT_W'(2));

  blifo_ram #(
    .WIDTH (blifo_pkg::DATA_WIDTH),
    .DEPTH (blifo_pkg::DEPTH)
  ) u_entries (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (blifo_pkg::ADDR_W'(count)),
    .wr_data (push_word),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Stack pointer and top register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    top_word <= top_word_next;
  end

  // Result buffer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (spare_valid) begin
      if (out_fire) begin
        spare_valid <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid || out_fire) begin
        out_valid <= 1'b1;
      end else begin
        spare_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  // Result buffer data.
  always_ff @(posedge clk) begin
    if (spare_valid) begin
      if (out_fire) begin
        out_word <= spare_word;
      end
    end else if (in_fire) begin
      if (!out_valid || out_fire) begin
        out_word <= res;
      end else begin
        spare_word <= res;
      end
    end
  end

  assign top_value   = out_word.top_value;
  assign value_valid = out_word.value_valid;
  assign status      = out_word.status;
  assign is_empty    = out_word.is_empty;
  assign is_full     = out_word.is_full;

  // The entry count never passes the storage depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    blifo_pkg::CMP_W'(count) <= blifo_pkg::CMP_W'(blifo_pkg::DEPTH))
    else $error("entry count beyond storage depth");

  // The spare word is only ever held behind a waiting head word.
  a_spare_behind_head: assert property (@(posedge clk) disable iff (rst)
    spare_valid |-> out_valid)
    else $error("spare word held without a head word");

  // An accepted push onto a stack below capacity raises the count by one.
  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    (in_fire && op == blifo_pkg::OP_PUSH && !full_now)
    |=> count == $past(count) + 1'b1)
    else $error("push did not advance the entry count");

  // After a successful push the top register holds the pushed word.
  a_push_top: assert property (@(posedge clk) disable iff (rst)
    (in_fire && op == blifo_pkg::OP_PUSH && !full_now)
    |=> top_word == $past(push_word))
    else $error("top register does not hold the pushed word");

  // A stalled head word with a full buffer keeps new operations out.
  a_buffer_full_stall: assert property (@(posedge clk) disable iff (rst)
    (spare_valid && !out_ready) |=> !in_ready)
    else $error("operation accepted while the result buffer was full");

endmodule
